>>> rtl/tcch_pkg.sv
package tcch_pkg;

    localparam int ATAN_LEN = 25;

    localparam logic [31:0] GAIN_INV_Q30 = 32'd652032874;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] CENTIDEG_PER_RAD_Q16 = 32'd375493621;
    localparam int HEADING_LIMIT = 18000;
    localparam int TILT_LIMIT = 9000;

    // atan(2^-i) in Q30, truncated
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] r;
        begin
            case (idx)
                0: r = 32'h3243F6A8;
                1: r = 32'h1DAC6705;
                2: r = 32'h0FADBAFC;
                3: r = 32'h07F56EA6;
                4: r = 32'h03FEAB76;
                5: r = 32'h01FFD55B;
                6: r = 32'h00FFFAAA;
                7: r = 32'h007FFF55;
                8: r = 32'h003FFFEA;
                9: r = 32'h001FFFFD;
                10: r = 32'h000FFFFF;
                11: r = 32'h0007FFFF;
                12: r = 32'h0003FFFF;
                13: r = 32'h0001FFFF;
                14: r = 32'h0000FFFF;
                15: r = 32'h00007FFF;
                16: r = 32'h00003FFF;
                17: r = 32'h00001FFF;
                18: r = 32'h00000FFF;
                19: r = 32'h000007FF;
                20: r = 32'h000003FF;
                21: r = 32'h000001FF;
                22: r = 32'h000000FF;
                23: r = 32'h0000007F;
                24: r = 32'h0000003F;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // Q30 angle rounded half up to the given fraction width
    function automatic logic signed [31:0] q30_to_angle(input logic [31:0] t, input int fb);
        logic [32:0] s;
        begin
            s = {1'b0, t};
            if (fb < 30)
                s = s + (33'd1 << (29 - fb));
            return 32'($signed(s >>> (30 - fb)));
        end
    endfunction

endpackage

>>> rtl/tcch_sqrt.sv
module tcch_sqrt
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] sq_in,
    output logic [31:0] root
);

    // restoring root, two radicand bits per stage, over (sq_in << 32)
    localparam int STEPS = 32;

    logic [63:0] rem_reg  [STEPS+1];
    logic [31:0] root_reg [STEPS+1];
    logic [63:0] rad_reg  [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            rad_reg[0]  <= {sq_in, 32'd0};
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [65:0] trial;
        logic [65:0] rem_sh;
        assign rem_sh = {rem_reg[k], rad_reg[k][63:62]};
        assign trial  = rem_sh - {32'd0, root_reg[k], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1] <= {rad_reg[k][61:0], 2'b00};
                if (!trial[65])
                begin
                    rem_reg[k+1]  <= trial[63:0];
                    root_reg[k+1] <= {root_reg[k][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= rem_sh[63:0];
                    root_reg[k+1] <= {root_reg[k][30:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[STEPS];

endmodule

>>> rtl/tcch_atan2.sv
module tcch_atan2 #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] y_in,
    input  logic signed [63:0] x_in,
    output logic signed [31:0] angle
);

    localparam int N = (CORDIC_ITERATIONS < tcch_pkg::ATAN_LEN) ?
                       CORDIC_ITERATIONS : tcch_pkg::ATAN_LEN;

    logic signed [65:0] x_reg [N+1];
    logic signed [65:0] y_reg [N+1];
    logic signed [31:0] z_reg [N+1];
    logic               zero_reg [N+1];

    // pre-rotate left half-plane vectors by a quarter turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0] <= 66'(y_in);
                    y_reg[0] <= -66'(x_in);
                    z_reg[0] <= tcch_pkg::q30_to_angle(tcch_pkg::HALF_PI_Q30, ANGLE_FRAC_BITS);
                end
                else
                begin
                    x_reg[0] <= -66'(y_in);
                    y_reg[0] <= 66'(x_in);
                    z_reg[0] <= -tcch_pkg::q30_to_angle(tcch_pkg::HALF_PI_Q30, ANGLE_FRAC_BITS);
                end
            end
            else
            begin
                x_reg[0] <= 66'(x_in);
                y_reg[0] <= 66'(y_in);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_it
        localparam logic signed [31:0] A =
            tcch_pkg::q30_to_angle(tcch_pkg::atan_q30(i), ANGLE_FRAC_BITS);
        logic signed [65:0] dx, dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][65])
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + A;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - A;
                end
            end
        end
    end

    assign angle = zero_reg[N] ? 32'sd0 : z_reg[N];

endmodule

>>> rtl/tcch_sincos.sv
module tcch_sincos #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] angle,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);

    localparam int N = (CORDIC_ITERATIONS < tcch_pkg::ATAN_LEN) ?
                       CORDIC_ITERATIONS : tcch_pkg::ATAN_LEN;

    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= 34'(tcch_pkg::GAIN_INV_Q30);
            y_reg[0] <= '0;
            z_reg[0] <= 34'(angle);
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_it
        localparam logic signed [31:0] A =
            tcch_pkg::q30_to_angle(tcch_pkg::atan_q30(i), ANGLE_FRAC_BITS);
        logic signed [33:0] dx, dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - 34'(A);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + 34'(A);
                end
            end
        end
    end

    assign cos_q30 = 32'(x_reg[N]);
    assign sin_q30 = 32'(y_reg[N]);

endmodule

>>> rtl/tcch_centideg.sv
module tcch_centideg #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int LIMIT           = 9000,
    parameter int W               = 15
)
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  angle,
    output logic signed [W-1:0] centi
);

    localparam int SH = ANGLE_FRAC_BITS + 16;

    logic        neg_reg, neg2_reg;
    logic [31:0] mag_reg;
    logic [63:0] prod_reg;

    // multiply magnitude, then round half away from zero and clamp
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= angle[31];
            mag_reg  <= angle[31] ? 32'(-angle) : 32'(angle);
            neg2_reg <= neg_reg;
            prod_reg <= 64'(mag_reg) * 64'(tcch_pkg::CENTIDEG_PER_RAD_Q16);
        end
    end

    logic [63:0] r;
    logic [W-1:0] v;
    assign r = (prod_reg + (64'd1 << (SH - 1))) >> SH;
    assign v = (r > 64'(LIMIT)) ? W'(LIMIT) : W'(r);
    assign centi = neg2_reg ? -$signed(v) : $signed(v);

endmodule

>>> rtl/tilt_compensated_compass_heading.sv
// Tilt-compensated compass. Each request carries raw accelerometer and
// magnetometer vectors and yields heading, pitch and roll in hundredths of a
// degree. The datapath is a fully pipelined chain: square sums (1 stage),
// square root (33 stages), CORDIC vectoring for pitch and roll, CORDIC
// rotation for sin/cos, product and sum stages, a second CORDIC vectoring for
// heading and degree scaling (2 stages). Each CORDIC takes N+1 stages, where
// N is CORDIC_ITERATIONS capped at 25. One request is taken every cycle
// unless the pipeline is stalled. A result held back by output stall freezes
// the whole pipeline and stalls the input in the same cycle.
module tilt_compensated_compass_heading #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    input  logic signed [15:0] mag_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] heading,
    output logic signed [14:0] pitch_angle,
    output logic signed [14:0] roll_angle
);

    localparam int N = (CORDIC_ITERATIONS < tcch_pkg::ATAN_LEN) ?
                       CORDIC_ITERATIONS : tcch_pkg::ATAN_LEN;
    // stage counts of each section
    localparam int L_SQ   = 1;
    localparam int L_SQRT = 33;
    localparam int L_AT   = N + 1;
    localparam int L_SC   = N + 1;
    localparam int L_MUL  = 1;
    localparam int L_SUM  = 2;
    localparam int L_CD   = 2;
    localparam int L_A    = L_SQ + L_SQRT;
    localparam int L_B    = L_A + L_AT;
    localparam int L_C    = L_B + L_SC;
    localparam int L_D    = L_C + L_MUL + L_SUM;
    localparam int L_E    = L_D + L_AT;
    localparam int LAT    = L_E + L_CD;

    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // valid pipeline
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end
    assign out_valid = vld_reg[LAT-1];

    // square sums
    logic [31:0] sqp_reg, sqr_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqp_reg <= 32'(accel_y * accel_y) + 32'(accel_z * accel_z);
            sqr_reg <= 32'(accel_x * accel_x) + 32'(accel_z * accel_z);
        end
    end

    // delay lines for raw axes
    logic signed [15:0] ax_d [L_A];
    logic signed [15:0] ay_d [L_A];
    logic signed [15:0] mx_d [L_C + L_MUL];
    logic signed [15:0] my_d [L_C + L_MUL];
    logic signed [15:0] mz_d [L_C + L_MUL];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_d[0] <= accel_x;
            ay_d[0] <= accel_y;
            for (int k = 1; k < L_A; k++)
            begin
                ax_d[k] <= ax_d[k-1];
                ay_d[k] <= ay_d[k-1];
            end
            mx_d[0] <= mag_x;
            my_d[0] <= mag_y;
            mz_d[0] <= mag_z;
            for (int k = 1; k < L_C + L_MUL; k++)
            begin
                mx_d[k] <= mx_d[k-1];
                my_d[k] <= my_d[k-1];
                mz_d[k] <= mz_d[k-1];
            end
        end
    end

    logic [31:0] rootp, rootr;
    tcch_sqrt u_sqp (.clk(clk), .en(en), .sq_in(sqp_reg), .root(rootp));
    tcch_sqrt u_sqr (.clk(clk), .en(en), .sq_in(sqr_reg), .root(rootr));

    logic signed [31:0] pitch, roll;
    tcch_atan2 #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
        u_atp (.clk(clk), .en(en),
               .y_in({{32{ax_d[L_A-1][15]}}, ax_d[L_A-1], 16'd0}),
               .x_in({32'd0, rootp}), .angle(pitch));
    tcch_atan2 #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
        u_atr (.clk(clk), .en(en),
               .y_in({{32{ay_d[L_A-1][15]}}, ay_d[L_A-1], 16'd0}),
               .x_in({32'd0, rootr}), .angle(roll));

    // hold pitch and roll until the heading angle is ready
    logic signed [31:0] pitch_d [L_SC + L_MUL + L_SUM + L_AT];
    logic signed [31:0] roll_d  [L_SC + L_MUL + L_SUM + L_AT];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_d[0] <= pitch;
            roll_d[0]  <= roll;
            for (int k = 1; k < L_SC + L_MUL + L_SUM + L_AT; k++)
            begin
                pitch_d[k] <= pitch_d[k-1];
                roll_d[k]  <= roll_d[k-1];
            end
        end
    end

    logic signed [31:0] cp, sp, cr, sr;
    tcch_sincos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
        u_scp (.clk(clk), .en(en), .angle(pitch), .cos_q30(cp), .sin_q30(sp));
    tcch_sincos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
        u_scr (.clk(clk), .en(en), .angle(roll), .cos_q30(cr), .sin_q30(sr));

    // trig products back to Q30, carry single terms alongside
    logic signed [31:0] ss_reg, cs_reg, cp_reg, sp_reg, cr_reg;
    logic signed [63:0] ssp, csp;
    assign ssp = 64'(sr) * 64'(sp);
    assign csp = 64'(cp) * 64'(sr);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg <= 32'(ssp >>> 30);
            cs_reg <= 32'(csp >>> 30);
            cp_reg <= cp;
            sp_reg <= sp;
            cr_reg <= cr;
        end
    end

    // raw axis times trig term, then sums
    logic signed [15:0] mx, my, mz;
    assign mx = mx_d[L_C + L_MUL - 1 + 0];
    assign my = my_d[L_C + L_MUL - 1];
    assign mz = mz_d[L_C + L_MUL - 1];
    logic signed [47:0] p_mycr_reg, p_mxss_reg, p_mzcs_reg, p_mxcp_reg, p_mzsp_reg;
    logic signed [63:0] hy_reg, hx_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_mycr_reg <= 48'(my) * 48'(cr_reg);
            p_mxss_reg <= 48'(mx) * 48'(ss_reg);
            p_mzcs_reg <= 48'(mz) * 48'(cs_reg);
            p_mxcp_reg <= 48'(mx) * 48'(cp_reg);
            p_mzsp_reg <= 48'(mz) * 48'(sp_reg);
            hy_reg <= 64'(p_mycr_reg) + 64'(p_mxss_reg) - 64'(p_mzcs_reg);
            hx_reg <= 64'(p_mxcp_reg) + 64'(p_mzsp_reg);
        end
    end

    logic signed [31:0] head;
    tcch_atan2 #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
        u_ath (.clk(clk), .en(en), .y_in(hy_reg), .x_in(hx_reg), .angle(head));

    tcch_centideg #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .LIMIT(tcch_pkg::HEADING_LIMIT), .W(16))
        u_cdh (.clk(clk), .en(en), .angle(head), .centi(heading));
    tcch_centideg #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .LIMIT(tcch_pkg::TILT_LIMIT), .W(15))
        u_cdp (.clk(clk), .en(en), .angle(pitch_d[L_SC + L_MUL + L_SUM + L_AT - 1]),
               .centi(pitch_angle));
    tcch_centideg #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .LIMIT(tcch_pkg::TILT_LIMIT), .W(15))
        u_cdr (.clk(clk), .en(en), .angle(roll_d[L_SC + L_MUL + L_SUM + L_AT - 1]),
               .centi(roll_angle));

endmodule

>>> rtl/tcch_checker.sv
module tcch_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] heading,
    input  logic signed [14:0] pitch_angle,
    input  logic signed [14:0] roll_angle
);

    // input stalls only when a result is held back
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)) else $error("spurious input stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(heading)))
        else $error("stalled result changed");

    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading <= 16'sd18000 && heading >= -16'sd18000))
        else $error("heading out of range");

    a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle <= 15'sd9000 && pitch_angle >= -15'sd9000 &&
                       roll_angle <= 15'sd9000 && roll_angle >= -15'sd9000))
        else $error("tilt out of range");

endmodule

bind tilt_compensated_compass_heading tcch_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .heading(heading), .pitch_angle(pitch_angle),
    .roll_angle(roll_angle)
);
